// ----- rtl/teletype_text_console_macros.svh -----
// Assertion macros shared by the console RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef TELETYPE_TEXT_CONSOLE_MACROS_SVH
`define TELETYPE_TEXT_CONSOLE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define TTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ttc_pkg.sv -----
// Shared types and codes for the teletype text console.
// No dependencies.
package ttc_pkg;

   typedef logic [1:0] action_type;
   typedef logic [7:0] char_type;
   typedef logic [7:0] attr_type;
   typedef logic [6:0] col_type;
   typedef logic [4:0] row_type;

   localparam action_type ACT_TELETYPE   = 2'd0;
   localparam action_type ACT_WRITE_CELL = 2'd1;
   localparam action_type ACT_READ_CELL  = 2'd2;
   localparam action_type ACT_SET_CURSOR = 2'd3;

   localparam char_type CHAR_BACKSPACE       = 8'h08;
   localparam char_type CHAR_LINE_FEED       = 8'h0a;
   localparam char_type CHAR_CARRIAGE_RETURN = 8'h0d;

   localparam logic [3:0] BLANK_NIBBLE = 4'h0;
   localparam logic [15:0] BLANK_CELL  = 16'h0000;

endpackage

// ----- rtl/ttc_req_if.sv -----
// Request channel of the console: valid/ready plus one command word.
// Depends on ttc_pkg.
interface ttc_req_if;
   logic                valid;
   logic                ready;
   ttc_pkg::action_type action;
   ttc_pkg::char_type   char_code;
   ttc_pkg::attr_type   colour_or_attr;
   ttc_pkg::col_type    column;
   ttc_pkg::row_type    row;

   modport source (output valid, action, char_code, colour_or_attr, column, row,
                   input ready);
   modport sink   (input valid, action, char_code, colour_or_attr, column, row,
                   output ready);
endinterface

// ----- rtl/ttc_rsp_if.sv -----
// Response channel of the console: valid/ready plus one result word.
// Depends on ttc_pkg.
interface ttc_rsp_if;
   logic              valid;
   logic              ready;
   ttc_pkg::char_type cell_character;
   ttc_pkg::attr_type cell_attribute;
   ttc_pkg::col_type  cursor_col;
   ttc_pkg::row_type  cursor_line;
   logic              did_scroll;

   modport source (output valid, cell_character, cell_attribute, cursor_col,
                   cursor_line, did_scroll, input ready);
   modport sink   (input valid, cell_character, cell_attribute, cursor_col,
                   cursor_line, did_scroll, output ready);
endinterface

// ----- rtl/teletype_text_console.sv -----
// Channel  | Dir | Word
// req_if   | in  | action, char_code, colour_or_attr, column, row
// rsp_if   | out | cell_character, cell_attribute, cursor_col, cursor_line, did_scroll
//
// One word at a time through the cell memory (synchronous read).
// Control codes, cell write, set cursor and off-screen read pass EXEC and DONE;
// a printable char adds MODIFY (read-modify-write), an on-screen read FETCH. A scroll
// adds a BLANK sweep over the new bottom row; rows use a circular base.
// After reset a clear sweep blanks every cell before req_if.ready.
// The result sits in an output register, so a new word is taken while it stalls.
// Depends on ttc_pkg, ttc_req_if, ttc_rsp_if, teletype_text_console_macros.svh.
`include "teletype_text_console_macros.svh"

module teletype_text_console #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic       clock,
   input logic       reset,
   ttc_req_if.sink   req_if,
   ttc_rsp_if.source rsp_if
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int RW1   = RW + 1;
   localparam int AW    = $clog2(CELLS);
   localparam logic [CW-1:0] LastCol  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);
   localparam logic [AW-1:0] LastCell = AW'(CELLS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_EXEC, ST_MODIFY, ST_FETCH, ST_BLANK, ST_DONE
   } state_type;

   // logical row -> physical row, rotated by the scroll base
   function automatic logic [RW-1:0] phys_row(logic [RW-1:0] r, logic [RW-1:0] b);
      logic [RW1-1:0] s;
      s = {1'b0, r} + {1'b0, b};
      if (s >= RW1'(ROWS)) s = s - RW1'(ROWS);
      return s[RW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
      return AW'(32'(r) * 32'(COLUMNS) + 32'(c));
   endfunction

   state_type           state_ff;
   logic [CW-1:0]       cur_col_ff;
   logic [RW-1:0]       cur_row_ff;
   logic [RW-1:0]       base_ff;
   logic [AW-1:0]       clr_addr_ff;
   logic [CW-1:0]       blank_col_ff;
   logic [RW-1:0]       blank_row_ff;

   ttc_pkg::action_type op_act_ff;
   ttc_pkg::char_type   op_char_ff;
   ttc_pkg::attr_type   op_attr_ff;
   ttc_pkg::col_type    op_col_ff;
   ttc_pkg::row_type    op_row_ff;

   ttc_pkg::char_type   res_char_ff;
   ttc_pkg::attr_type   res_attr_ff;
   logic                res_scroll_ff;

   logic                rsp_valid_ff;
   ttc_pkg::char_type   rsp_char_ff;
   ttc_pkg::attr_type   rsp_attr_ff;
   ttc_pkg::col_type    rsp_col_ff;
   ttc_pkg::row_type    rsp_line_ff;
   logic                rsp_scroll_ff;

   logic [15:0]         cells_mem [CELLS];
   logic [15:0]         mem_rdata_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   logic [15:0]         mem_wdata;

   logic                op_col_ok;
   logic                op_row_ok;
   logic [CW-1:0]       sat_col;
   logic [RW-1:0]       sat_row;
   logic [AW-1:0]       op_addr;
   logic [AW-1:0]       cur_addr;
   logic [RW-1:0]       base_next;
   logic                rsp_free;

   always_comb begin
      op_col_ok = 32'(op_col_ff) < 32'(COLUMNS);
      op_row_ok = 32'(op_row_ff) < 32'(ROWS);
      sat_col   = op_col_ok ? CW'(op_col_ff) : LastCol;
      sat_row   = op_row_ok ? RW'(op_row_ff) : LastRow;
      op_addr   = cell_addr(phys_row(sat_row, base_ff), sat_col);
      cur_addr  = cell_addr(phys_row(cur_row_ff, base_ff), cur_col_ff);
      base_next = (base_ff == LastRow) ? '0 : base_ff + RW'(1);
      rsp_free  = !rsp_valid_ff || rsp_if.ready;
   end

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = ttc_pkg::BLANK_CELL;
      mem_raddr = (op_act_ff == ttc_pkg::ACT_TELETYPE) ? cur_addr : op_addr;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
         end
         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(blank_row_ff, blank_col_ff);
         end
         ST_MODIFY: begin
            // keep background nibble, take new foreground
            mem_we    = 1'b1;
            mem_wdata = {mem_rdata_ff[15:12], op_attr_ff[3:0], op_char_ff};
         end
         ST_EXEC: begin
            if (op_act_ff == ttc_pkg::ACT_WRITE_CELL && op_col_ok && op_row_ok) begin
               mem_we    = 1'b1;
               mem_waddr = op_addr;
               mem_wdata = {op_attr_ff, op_char_ff};
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) cells_mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= cells_mem[mem_raddr];
   end

   // command payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_if.valid) begin
         op_act_ff  <= req_if.action;
         op_char_ff <= req_if.char_code;
         op_attr_ff <= req_if.colour_or_attr;
         op_col_ff  <= req_if.column;
         op_row_ff  <= req_if.row;
      end
   end

   // sequencer, cursor, scroll state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         base_ff       <= '0;
         clr_addr_ff   <= '0;
         blank_col_ff  <= '0;
         blank_row_ff  <= '0;
         res_char_ff   <= '0;
         res_attr_ff   <= '0;
         res_scroll_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_char_ff   <= '0;
         rsp_attr_ff   <= '0;
         rsp_col_ff    <= '0;
         rsp_line_ff   <= '0;
         rsp_scroll_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == LastCell) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_if.valid) begin
                  res_char_ff   <= '0;
                  res_attr_ff   <= '0;
                  res_scroll_ff <= 1'b0;
                  state_ff      <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               case (op_act_ff)
                  ttc_pkg::ACT_TELETYPE: begin
                     case (op_char_ff)
                        ttc_pkg::CHAR_BACKSPACE: begin
                           if (cur_col_ff != '0) cur_col_ff <= cur_col_ff - CW'(1);
                           state_ff <= ST_DONE;
                        end
                        ttc_pkg::CHAR_LINE_FEED: begin
                           if (cur_row_ff == LastRow) begin
                              base_ff       <= base_next;
                              blank_row_ff  <= base_ff;
                              blank_col_ff  <= '0;
                              res_scroll_ff <= 1'b1;
                              state_ff      <= ST_BLANK;
                           end else begin
                              cur_row_ff <= cur_row_ff + RW'(1);
                              state_ff   <= ST_DONE;
                           end
                        end
                        ttc_pkg::CHAR_CARRIAGE_RETURN: begin
                           cur_col_ff <= '0;
                           state_ff   <= ST_DONE;
                        end
                        default: begin
                           state_ff <= ST_MODIFY;
                        end
                     endcase
                  end
                  ttc_pkg::ACT_READ_CELL: begin
                     state_ff <= (op_col_ok && op_row_ok) ? ST_FETCH : ST_DONE;
                  end
                  ttc_pkg::ACT_SET_CURSOR: begin
                     cur_col_ff <= sat_col;
                     cur_row_ff <= sat_row;
                     state_ff   <= ST_DONE;
                  end
                  default: begin
                     state_ff <= ST_DONE;
                  end
               endcase
            end
            ST_MODIFY: begin
               if (cur_col_ff == LastCol) begin
                  cur_col_ff <= '0;
                  if (cur_row_ff == LastRow) begin
                     base_ff       <= base_next;
                     blank_row_ff  <= base_ff;
                     blank_col_ff  <= '0;
                     res_scroll_ff <= 1'b1;
                     state_ff      <= ST_BLANK;
                  end else begin
                     cur_row_ff <= cur_row_ff + RW'(1);
                     state_ff   <= ST_DONE;
                  end
               end else begin
                  cur_col_ff <= cur_col_ff + CW'(1);
                  state_ff   <= ST_DONE;
               end
            end
            ST_FETCH: begin
               res_char_ff <= mem_rdata_ff[7:0];
               res_attr_ff <= mem_rdata_ff[15:8];
               state_ff    <= ST_DONE;
            end
            ST_BLANK: begin
               blank_col_ff <= blank_col_ff + CW'(1);
               if (blank_col_ff == LastCol) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_char_ff   <= res_char_ff;
                  rsp_attr_ff   <= res_attr_ff;
                  rsp_col_ff    <= 7'(cur_col_ff);
                  rsp_line_ff   <= 5'(cur_row_ff);
                  rsp_scroll_ff <= res_scroll_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.cell_character = rsp_char_ff;
   assign rsp_if.cell_attribute = rsp_attr_ff;
   assign rsp_if.cursor_col     = rsp_col_ff;
   assign rsp_if.cursor_line    = rsp_line_ff;
   assign rsp_if.did_scroll     = rsp_scroll_ff;

   `TTC_ASSERT_IMPLY(a_cursor_on_screen, clock, reset, 1'b1,
                     (cur_col_ff <= LastCol) && (cur_row_ff <= LastRow), "cursor off screen")
   `TTC_ASSERT_IMPLY(a_base_in_range, clock, reset, 1'b1, base_ff <= LastRow,
                     "scroll base out of range")
   `TTC_ASSERT_IMPLY(a_busy_no_accept, clock, reset,
                     (state_ff == ST_CLEAR) || (state_ff == ST_BLANK), !req_if.ready,
                     "word taken while sweeping memory")
   `TTC_ASSERT_IMPLY(a_blank_on_last_row, clock, reset, state_ff == ST_BLANK,
                     (cur_row_ff == LastRow) && res_scroll_ff, "blanking without scroll")
   `TTC_ASSERT_NEXT(a_rsp_only_from_done, clock, reset,
                    !rsp_valid_ff && (state_ff != ST_DONE), !rsp_valid_ff,
                    "response without finished word")

endmodule

// ----- dv/tb_teletype_text_console.sv -----
// Self-checking testbench for teletype_text_console: directed and random command words,
// random pacing on both channels, one long output stall, scoreboard against a local model.
// Depends on ttc_pkg, ttc_req_if, ttc_rsp_if and the console RTL.
module tb_teletype_text_console;
   timeunit 1ns;
   timeprecision 1ps;

   import ttc_pkg::*;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELLS       = COLUMNS * ROWS;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      action_type action;
      char_type   char_code;
      attr_type   colour_or_attr;
      col_type    column;
      row_type    row;
   } console_cmd_type;

   typedef struct packed {
      char_type ch;
      attr_type attr;
      col_type  col;
      row_type  line;
      logic     scrolled;
   } console_view_type;

   logic clock = 1'b0;
   logic reset;

   ttc_req_if req_if ();
   ttc_rsp_if rsp_if ();

   teletype_text_console #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   // console model state
   logic [15:0]      screen_model [0:CELLS-1];
   int unsigned      cursor_col_model;
   int unsigned      cursor_row_model;
   console_view_type pending_views[$];

   int error_count;
   int words_sent;
   int scroll_count;
   int read_count;
   int cycle_count;
   int send_idle_pct;
   int rsp_idle_pct;
   int rsp_hold_request;
   int rsp_hold_left;

   task automatic report_error(input string msg);
      if (error_count < 40)
         $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic console_cmd_type make_cmd(input action_type a, input int ch,
                                                input int ca, input int c, input int r);
      console_cmd_type w;
      w.action         = a;
      w.char_code      = char_type'(ch);
      w.colour_or_attr = attr_type'(ca);
      w.column         = col_type'(c);
      w.row            = row_type'(r);
      return w;
   endfunction

   // Advances the model by one command word and returns the word the block must answer.
   function automatic console_view_type apply_console_word(input console_cmd_type w);
      console_view_type v;
      int unsigned      col;
      int unsigned      line;
      int unsigned      idx;
      int               i;
      bit               on_screen;
      v         = '0;
      col       = cursor_col_model;
      line      = cursor_row_model;
      on_screen = (w.column < COLUMNS) && (w.row < ROWS);
      case (w.action)
         ACT_TELETYPE: begin
            if (w.char_code == CHAR_BACKSPACE) begin
               if (col > 0) col--;
            end else if (w.char_code == CHAR_LINE_FEED) begin
               line++;
            end else if (w.char_code == CHAR_CARRIAGE_RETURN) begin
               col = 0;
            end else begin
               idx = line * COLUMNS + col;
               // background nibble stays, foreground comes from the word
               screen_model[idx] = {screen_model[idx][15:12], w.colour_or_attr[3:0],
                                    w.char_code};
               col++;
               if (col > COLUMNS - 1) begin
                  col = 0;
                  line++;
               end
            end
            if (line > ROWS - 1) begin
               for (i = 0; i < CELLS - COLUMNS; i++)
                  screen_model[i] = screen_model[i + COLUMNS];
               for (i = CELLS - COLUMNS; i < CELLS; i++)
                  screen_model[i] = BLANK_CELL;
               line       = ROWS - 1;
               v.scrolled = 1'b1;
            end
            cursor_col_model = col;
            cursor_row_model = line;
         end
         ACT_WRITE_CELL: begin
            if (on_screen)
               screen_model[w.row * COLUMNS + w.column] = {w.colour_or_attr, w.char_code};
         end
         ACT_READ_CELL: begin
            if (on_screen) begin
               idx    = w.row * COLUMNS + w.column;
               v.ch   = screen_model[idx][7:0];
               v.attr = screen_model[idx][15:8];
            end
         end
         ACT_SET_CURSOR: begin
            cursor_col_model = (w.column > COLUMNS - 1) ? COLUMNS - 1 : w.column;
            cursor_row_model = (w.row > ROWS - 1) ? ROWS - 1 : w.row;
         end
      endcase
      v.col  = col_type'(cursor_col_model);
      v.line = row_type'(cursor_row_model);
      return v;
   endfunction

   // Offers one word after random idle cycles; returns at the accepting edge.
   task automatic send_word(input console_cmd_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.action         <= w.action;
      req_if.char_code      <= w.char_code;
      req_if.colour_or_attr <= w.colour_or_attr;
      req_if.column         <= w.column;
      req_if.row            <= w.row;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      pending_views.push_back(apply_console_word(w));
      words_sent++;
      if (w.action == ACT_READ_CELL) read_count++;
   endtask

   // Called right after an accepted word: drops valid and waits for every answer.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   // output side pacing; a requested hold keeps ready low until rsp_hold_left runs out
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            rsp_hold_left    = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_console_words
      console_view_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_views.size() == 0) begin
            report_error("answer word with no command waiting");
         end else begin
            want = pending_views.pop_front();
            if (want.scrolled) scroll_count++;
            if (rsp_if.cell_character !== want.ch)
               report_error($sformatf("cell_character got %0h want %0h",
                                      rsp_if.cell_character, want.ch));
            if (rsp_if.cell_attribute !== want.attr)
               report_error($sformatf("cell_attribute got %0h want %0h",
                                      rsp_if.cell_attribute, want.attr));
            if (rsp_if.cursor_col !== want.col)
               report_error($sformatf("cursor_col got %0d want %0d",
                                      rsp_if.cursor_col, want.col));
            if (rsp_if.cursor_line !== want.line)
               report_error($sformatf("cursor_line got %0d want %0d",
                                      rsp_if.cursor_line, want.line));
            if (rsp_if.did_scroll !== want.scrolled)
               report_error($sformatf("did_scroll got %0b want %0b",
                                      rsp_if.did_scroll, want.scrolled));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: run timed out after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_cell_access();
      send_word(make_cmd(ACT_READ_CELL, 8'h00, 8'h00, 0, 0));
      send_word(make_cmd(ACT_WRITE_CELL, 8'hff, 8'hff, 79, 24));
      send_word(make_cmd(ACT_WRITE_CELL, 8'h41, 8'h1e, 0, 0));
      send_word(make_cmd(ACT_READ_CELL, 8'h00, 8'h00, 0, 0));
      send_word(make_cmd(ACT_READ_CELL, 8'h00, 8'h00, 79, 24));
      // off-screen write is dropped, off-screen read answers zero
      send_word(make_cmd(ACT_WRITE_CELL, 8'h55, 8'haa, 127, 31));
      send_word(make_cmd(ACT_WRITE_CELL, 8'h55, 8'haa, 0, 25));
      send_word(make_cmd(ACT_READ_CELL, 8'hff, 8'hff, 127, 31));
   endtask

   task automatic test_cursor_control();
      send_word(make_cmd(ACT_SET_CURSOR, 8'h00, 8'h00, 127, 31));
      send_word(make_cmd(ACT_SET_CURSOR, 8'h00, 8'h00, 80, 3));
      send_word(make_cmd(ACT_SET_CURSOR, 8'h00, 8'h00, 5, 25));
      send_word(make_cmd(ACT_SET_CURSOR, 8'h00, 8'h00, 0, 0));
      send_word(make_cmd(ACT_TELETYPE, CHAR_BACKSPACE, 8'h07, 0, 0));
      send_word(make_cmd(ACT_SET_CURSOR, 8'h00, 8'h00, 37, 12));
      send_word(make_cmd(ACT_TELETYPE, CHAR_BACKSPACE, 8'h07, 0, 0));
      send_word(make_cmd(ACT_TELETYPE, CHAR_CARRIAGE_RETURN, 8'h07, 0, 0));
      send_word(make_cmd(ACT_TELETYPE, CHAR_LINE_FEED, 8'h07, 0, 0));
   endtask

   task automatic test_wrap_and_scroll();
      // last cell: wraps past the last column and scrolls
      send_word(make_cmd(ACT_SET_CURSOR, 8'h00, 8'h00, 79, 24));
      send_word(make_cmd(ACT_TELETYPE, 8'h41, 8'hff, 0, 0));
      send_word(make_cmd(ACT_READ_CELL, 8'h00, 8'h00, 79, 23));
      send_word(make_cmd(ACT_READ_CELL, 8'h00, 8'h00, 79, 24));
      // line feed on the bottom row keeps the column
      send_word(make_cmd(ACT_SET_CURSOR, 8'h00, 8'h00, 37, 24));
      send_word(make_cmd(ACT_TELETYPE, CHAR_LINE_FEED, 8'h00, 0, 0));
      send_word(make_cmd(ACT_TELETYPE, 8'h00, 8'hf0, 0, 0));
      send_word(make_cmd(ACT_TELETYPE, 8'hff, 8'h0f, 127, 31));
      send_word(make_cmd(ACT_READ_CELL, 8'h00, 8'h00, 37, 24));
      send_word(make_cmd(ACT_READ_CELL, 8'h00, 8'h00, 38, 24));
   endtask

   function automatic console_cmd_type random_cmd();
      int pick;
      int ch;
      int c;
      int r;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) begin
         c = $urandom_range(0, COLUMNS - 1);
         r = ($urandom_range(0, 1) != 0) ? $urandom_range(ROWS - 5, ROWS - 1)
                                         : $urandom_range(0, ROWS - 1);
      end else begin
         c = $urandom_range(0, 127);
         r = $urandom_range(0, 31);
      end
      if (pick < 55) begin
         pick = $urandom_range(0, 99);
         ch = (pick < 12) ? int'(CHAR_LINE_FEED) :
              (pick < 18) ? int'(CHAR_CARRIAGE_RETURN) :
              (pick < 24) ? int'(CHAR_BACKSPACE) : $urandom_range(0, 255);
         return make_cmd(ACT_TELETYPE, ch, $urandom_range(0, 255),
                         $urandom_range(0, 127), $urandom_range(0, 31));
      end
      if (pick < 72)
         return make_cmd(ACT_WRITE_CELL, $urandom_range(0, 255), $urandom_range(0, 255), c, r);
      if (pick < 92)
         return make_cmd(ACT_READ_CELL, $urandom_range(0, 255), $urandom_range(0, 255), c, r);
      // half the time the cursor goes near the right edge and bottom so wraps and scrolls happen
      if ($urandom_range(0, 1) != 0) begin
         c = $urandom_range(COLUMNS - 20, 127);
         r = $urandom_range(ROWS - 3, 31);
      end
      return make_cmd(ACT_SET_CURSOR, $urandom_range(0, 255), $urandom_range(0, 255), c, r);
   endfunction

   task automatic test_output_stall();
      int i;
      send_idle_pct    = 0;
      rsp_idle_pct     = 0;
      rsp_hold_request = 300;
      for (i = 0; i < 30; i++)
         send_word(random_cmd());
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
      int i;
      send_idle_pct = s_idle;
      rsp_idle_pct  = r_idle;
      for (i = 0; i < count; i++)
         send_word(random_cmd());
      wait_for_drain();
   endtask

   initial begin
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.action         <= ACT_TELETYPE;
      req_if.char_code      <= '0;
      req_if.colour_or_attr <= '0;
      req_if.column         <= '0;
      req_if.row            <= '0;
      foreach (screen_model[i]) screen_model[i] = BLANK_CELL;
      cursor_col_model = 0;
      cursor_row_model = 0;
      send_idle_pct    = 28;
      rsp_idle_pct     = 78;
      rsp_hold_request = 0;
      rsp_hold_left    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_cell_access();
      test_cursor_control();
      test_wrap_and_scroll();
      wait_for_drain();
      test_output_stall();
      test_random_traffic(190, 28, 78);
      test_random_traffic(190, 78, 28);
      test_random_traffic(190, 0, 0);

      // a scroll keeps the block busy while it blanks a row
      repeat (COLUMNS * 4 + 20) @(posedge clock);
      if (pending_views.size() != 0)
         report_error($sformatf("%0d answer words never arrived", pending_views.size()));

      $display("Run covered %0d command words: %0d cell reads, %0d scrolls,",
               words_sent, read_count, scroll_count);
      $display("three pacing mixes and one long output stall; %0d mismatches.", error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
